>>> design/two_class_ticket_queue_arbiter_defines.svh
// assertion macros for the two-class ticket queue arbiter
`ifndef TWO_CLASS_TICKET_QUEUE_ARBITER_DEFINES_SVH
`define TWO_CLASS_TICKET_QUEUE_ARBITER_DEFINES_SVH

// same-cycle implication
`define TCQA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcqa assertion failed");

// next-cycle implication
`define TCQA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcqa assertion failed");

`endif

>>> design/tcqa_pkg.sv
// types and constants shared by the ticket queue arbiter modules
`default_nettype none
package tcqa_pkg;

    localparam int TICKET_W = 16;
    localparam int TIME_W   = 17;
    localparam int ENTRY_W  = TICKET_W + TIME_W;

    localparam logic [2:0] REQ_ISSUE_N = 3'd0;
    localparam logic [2:0] REQ_ISSUE_P = 3'd1;
    localparam logic [2:0] REQ_CALL    = 3'd2;
    localparam logic [2:0] REQ_SEARCH  = 3'd3;
    localparam logic [2:0] REQ_CANCEL  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam logic [7:0] RATIO_RESET = 8'd2;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ISSUE,
        CMD_UNUSED,
        CMD_EMPTY,
        CMD_CALL_RD,
        CMD_CALL_OUT,
        CMD_SRCH_INIT,
        CMD_SRCH_RD,
        CMD_SRCH_NEXTQ,
        CMD_SRCH_MISS,
        CMD_SRCH_STEP,
        CMD_FOUND_OUT,
        CMD_FOUND_HOLD,
        CMD_SHIFT_RD,
        CMD_SHIFT_WR,
        CMD_SHIFT_DONE
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALL,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR
    } state_t;

    typedef struct packed {
        logic [2:0] req_in;
        logic       empty;
        logic       search_end;
        logic       sel;
        logic       match;
        logic       is_cancel;
        logic       shift_end;
    } dp_status_t;

endpackage
`default_nettype wire

>>> design/tcqa_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module tcqa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> design/tcqa_ctrl.sv
// sequencing state machine for the ticket queue arbiter
`default_nettype none
module tcqa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tcqa_pkg::dp_status_t st,
    output tcqa_pkg::cmd_t      cmd,
    output logic                busy
);
    import tcqa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (st.req_in)
                        REQ_ISSUE_N, REQ_ISSUE_P: cmd = CMD_ISSUE;
                        REQ_CALL:
                        begin
                            if (st.empty)
                            begin
                                cmd = CMD_EMPTY;
                            end
                            else
                            begin
                                cmd        = CMD_CALL_RD;
                                state_next = S_CALL;
                            end
                        end
                        REQ_SEARCH, REQ_CANCEL:
                        begin
                            cmd        = CMD_SRCH_INIT;
                            state_next = S_SRCH_RD;
                        end
                        default: cmd = CMD_UNUSED;
                    endcase
                end
            end
            S_CALL:
            begin
                cmd        = CMD_CALL_OUT;
                state_next = S_IDLE;
            end
            S_SRCH_RD:
            begin
                if (!st.search_end)
                begin
                    cmd        = CMD_SRCH_RD;
                    state_next = S_SRCH_CMP;
                end
                else if (!st.sel)
                begin
                    cmd = CMD_SRCH_NEXTQ;
                end
                else
                begin
                    cmd        = CMD_SRCH_MISS;
                    state_next = S_IDLE;
                end
            end
            S_SRCH_CMP:
            begin
                if (!st.match)
                begin
                    cmd        = CMD_SRCH_STEP;
                    state_next = S_SRCH_RD;
                end
                else if (st.is_cancel)
                begin
                    cmd        = CMD_FOUND_HOLD;
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    cmd        = CMD_FOUND_OUT;
                    state_next = S_IDLE;
                end
            end
            S_SHIFT_RD:
            begin
                if (st.shift_end)
                begin
                    cmd        = CMD_SHIFT_DONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd        = CMD_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd        = CMD_SHIFT_WR;
                state_next = S_SHIFT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> design/tcqa_dp.sv
// queue storage, counters and result registers of the ticket queue arbiter
`default_nettype none
module tcqa_dp #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcqa_pkg::cmd_t       cmd,
    output tcqa_pkg::dp_status_t st,
    input  logic [2:0]           req_type,
    input  logic [15:0]          ticket,
    input  logic [16:0]          arrival_time,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_data,
    output logic                 done,
    output logic [1:0]           status,
    output logic [15:0]          ticket_out,
    output logic                 ticket_class,
    output logic [16:0]          ticket_time,
    output logic [7:0]           queue_position,
    output logic [7:0]           normal_waiting,
    output logic [7:0]           preferential_waiting,
    output logic [15:0]          total_served,
    output logic [15:0]          normal_served,
    output logic [15:0]          preferential_served
);
    import tcqa_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // control state
    logic [CW-1:0] ncount_reg, ncount_next, pcount_reg, pcount_next;
    logic [AW-1:0] nhead_reg, nhead_next, phead_reg, phead_next;
    logic [15:0]   last_reg, last_next;
    logic [7:0]    nsp_reg, nsp_next, ratio_reg, ratio_next;
    logic [15:0]   tot_reg, tot_next, nsv_reg, nsv_next, psv_reg, psv_next;
    logic          done_reg, done_next;

    // payload
    logic          sel_reg, sel_next;
    logic [CW-1:0] idx_reg, idx_next, fpos_reg, fpos_next;
    logic [15:0]   tk_reg, tk_next;
    logic [2:0]    req_reg, req_next;
    logic [16:0]   ftime_reg, ftime_next;
    logic [1:0]    status_reg, status_next;
    logic [15:0]   tout_reg, tout_next;
    logic          cls_reg, cls_next;
    logic [16:0]   time_reg, time_next;
    logic [CW-1:0] pos_reg, pos_next;

    // memory ports
    logic               n_we, p_we;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data, n_rd, p_rd, rd_entry;

    logic [CW-1:0] cnt_sel, idx_inc, qcnt;
    logic [AW-1:0] head_sel;
    logic          pref_pick, issue_p;
    logic [31:0]   pos_w, nw_w, pw_w;

    tcqa_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_nram (
        .clk(clk), .we(n_we), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(n_rd)
    );

    tcqa_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_pram (
        .clk(clk), .we(p_we), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(p_rd)
    );

    assign cnt_sel   = sel_reg ? pcount_reg : ncount_reg;
    assign head_sel  = sel_reg ? phead_reg : nhead_reg;
    assign rd_entry  = sel_reg ? p_rd : n_rd;
    assign idx_inc   = idx_reg + CW'(1);
    assign issue_p   = (req_type == REQ_ISSUE_P);
    assign qcnt      = issue_p ? pcount_reg : ncount_reg;
    assign pref_pick = (pcount_reg != '0) &&
                       ((nsp_reg >= ratio_reg) || (ncount_reg == '0));

    assign st.req_in     = req_type;
    assign st.empty      = (ncount_reg == '0) && (pcount_reg == '0);
    assign st.search_end = (idx_reg >= cnt_sel);
    assign st.sel        = sel_reg;
    assign st.match      = (rd_entry[ENTRY_W-1:TIME_W] == tk_reg);
    assign st.is_cancel  = (req_reg == REQ_CANCEL);
    assign st.shift_end  = ((CW+1)'(idx_reg) + (CW+1)'(1)) >= (CW+1)'(cnt_sel);

    always_comb
    begin
        ncount_next = ncount_reg;
        pcount_next = pcount_reg;
        nhead_next  = nhead_reg;
        phead_next  = phead_reg;
        last_next   = last_reg;
        nsp_next    = nsp_reg;
        ratio_next  = cfg_valid ? cfg_data : ratio_reg;
        tot_next    = tot_reg;
        nsv_next    = nsv_reg;
        psv_next    = psv_reg;
        done_next   = 1'b0;
        sel_next    = sel_reg;
        idx_next    = idx_reg;
        fpos_next   = fpos_reg;
        tk_next     = tk_reg;
        req_next    = req_reg;
        ftime_next  = ftime_reg;
        status_next = status_reg;
        tout_next   = tout_reg;
        cls_next    = cls_reg;
        time_next   = time_reg;
        pos_next    = pos_reg;
        n_we        = 1'b0;
        p_we        = 1'b0;
        wr_addr     = ring_addr(head_sel, idx_reg);
        wr_data     = rd_entry;
        rd_addr     = ring_addr(head_sel, idx_reg);

        unique case (cmd)
            CMD_ISSUE:
            begin
                done_next   = 1'b1;
                cls_next    = issue_p;
                pos_next    = '0;
                if (qcnt >= CW'(QUEUE_DEPTH))
                begin
                    status_next = ST_FULL;
                    tout_next   = '0;
                    time_next   = '0;
                end
                else
                begin
                    last_next   = (last_reg == 16'hFFFF) ? 16'd1 : last_reg + 16'd1;
                    status_next = ST_OK;
                    tout_next   = last_next;
                    time_next   = arrival_time;
                    wr_data     = {last_next, arrival_time};
                    if (issue_p)
                    begin
                        wr_addr     = ring_addr(phead_reg, pcount_reg);
                        p_we        = 1'b1;
                        pcount_next = pcount_reg + CW'(1);
                    end
                    else
                    begin
                        wr_addr     = ring_addr(nhead_reg, ncount_reg);
                        n_we        = 1'b1;
                        ncount_next = ncount_reg + CW'(1);
                    end
                end
            end
            CMD_UNUSED, CMD_EMPTY:
            begin
                done_next   = 1'b1;
                status_next = (cmd == CMD_EMPTY) ? ST_EMPTY : ST_OK;
                tout_next   = '0;
                cls_next    = 1'b0;
                time_next   = '0;
                pos_next    = '0;
            end
            CMD_CALL_RD:
            begin
                sel_next = pref_pick;
                rd_addr  = pref_pick ? phead_reg : nhead_reg;
            end
            CMD_CALL_OUT:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                tout_next   = rd_entry[ENTRY_W-1:TIME_W];
                time_next   = rd_entry[TIME_W-1:0];
                cls_next    = sel_reg;
                pos_next    = '0;
                tot_next    = sat16(tot_reg);
                if (sel_reg)
                begin
                    phead_next  = ring_addr(phead_reg, CW'(1));
                    pcount_next = pcount_reg - CW'(1);
                    nsp_next    = '0;
                    psv_next    = sat16(psv_reg);
                end
                else
                begin
                    nhead_next  = ring_addr(nhead_reg, CW'(1));
                    ncount_next = ncount_reg - CW'(1);
                    nsp_next    = (nsp_reg == 8'hFF) ? nsp_reg : nsp_reg + 8'd1;
                    nsv_next    = sat16(nsv_reg);
                end
            end
            CMD_SRCH_INIT:
            begin
                tk_next  = ticket;
                req_next = req_type;
                sel_next = 1'b0;
                idx_next = '0;
            end
            CMD_SRCH_RD:
            begin
                rd_addr = ring_addr(head_sel, idx_reg);
            end
            CMD_SRCH_NEXTQ:
            begin
                sel_next = 1'b1;
                idx_next = '0;
            end
            CMD_SRCH_MISS:
            begin
                done_next   = 1'b1;
                status_next = ST_MISSING;
                tout_next   = tk_reg;
                cls_next    = 1'b0;
                time_next   = '0;
                pos_next    = '0;
            end
            CMD_SRCH_STEP:
            begin
                idx_next = idx_inc;
            end
            CMD_FOUND_OUT:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                tout_next   = tk_reg;
                cls_next    = sel_reg;
                time_next   = rd_entry[TIME_W-1:0];
                pos_next    = idx_inc;
            end
            CMD_FOUND_HOLD:
            begin
                ftime_next = rd_entry[TIME_W-1:0];
                fpos_next  = idx_inc;
            end
            CMD_SHIFT_RD:
            begin
                rd_addr = ring_addr(head_sel, idx_inc);
            end
            CMD_SHIFT_WR:
            begin
                wr_addr  = ring_addr(head_sel, idx_reg);
                wr_data  = rd_entry;
                n_we     = !sel_reg;
                p_we     = sel_reg;
                idx_next = idx_inc;
            end
            CMD_SHIFT_DONE:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                tout_next   = tk_reg;
                cls_next    = sel_reg;
                time_next   = ftime_reg;
                pos_next    = fpos_reg;
                if (sel_reg)
                begin
                    pcount_next = pcount_reg - CW'(1);
                end
                else
                begin
                    ncount_next = ncount_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncount_reg <= '0;
            pcount_reg <= '0;
            nhead_reg  <= '0;
            phead_reg  <= '0;
            last_reg   <= '0;
            nsp_reg    <= '0;
            ratio_reg  <= RATIO_RESET;
            tot_reg    <= '0;
            nsv_reg    <= '0;
            psv_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ncount_reg <= ncount_next;
            pcount_reg <= pcount_next;
            nhead_reg  <= nhead_next;
            phead_reg  <= phead_next;
            last_reg   <= last_next;
            nsp_reg    <= nsp_next;
            ratio_reg  <= ratio_next;
            tot_reg    <= tot_next;
            nsv_reg    <= nsv_next;
            psv_reg    <= psv_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        idx_reg    <= idx_next;
        fpos_reg   <= fpos_next;
        tk_reg     <= tk_next;
        req_reg    <= req_next;
        ftime_reg  <= ftime_next;
        status_reg <= status_next;
        tout_reg   <= tout_next;
        cls_reg    <= cls_next;
        time_reg   <= time_next;
        pos_reg    <= pos_next;
    end

    assign pos_w = 32'(pos_reg);
    assign nw_w  = 32'(ncount_reg);
    assign pw_w  = 32'(pcount_reg);

    assign done                 = done_reg;
    assign status               = status_reg;
    assign ticket_out           = tout_reg;
    assign ticket_class         = cls_reg;
    assign ticket_time          = time_reg;
    assign queue_position       = pos_w[7:0];
    assign normal_waiting       = nw_w[7:0];
    assign preferential_waiting = pw_w[7:0];
    assign total_served         = tot_reg;
    assign normal_served        = nsv_reg;
    assign preferential_served  = psv_reg;
endmodule
`default_nettype wire

>>> design/two_class_ticket_queue_arbiter.sv
// top level of the two-class ticket queue arbiter
//
//  channel   signals                                  transfer
//  request   start, busy, req_type, ticket,           start && !busy
//            arrival_time
//  result    done, status, ticket_out, ...            done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_data           cfg_valid && cfg_ready
//
// issue and unused codes: result in the cycle after the item; call: via S_CALL
// search: S_SRCH_RD, S_SRCH_CMP per entry visited; both queues share one read address
// cancel: search, then S_SHIFT_RD and S_SHIFT_WR per entry moved up
// rst_n clears counts, heads and counters and sets the ratio to 2; no clearing pass
// busy stays high until the result strobe is issued; results cannot be stalled
`default_nettype none
module two_class_ticket_queue_arbiter #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [15:0] ticket,
    input  logic [16:0] arrival_time,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] ticket_out,
    output logic        ticket_class,
    output logic [16:0] ticket_time,
    output logic [7:0]  queue_position,
    output logic [7:0]  normal_waiting,
    output logic [7:0]  preferential_waiting,
    output logic [15:0] total_served,
    output logic [15:0] normal_served,
    output logic [15:0] preferential_served,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import tcqa_pkg::*;

    cmd_t       cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    tcqa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .st(st), .cmd(cmd), .busy(busy)
    );

    tcqa_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .req_type(req_type), .ticket(ticket), .arrival_time(arrival_time),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data),
        .done(done), .status(status), .ticket_out(ticket_out),
        .ticket_class(ticket_class), .ticket_time(ticket_time),
        .queue_position(queue_position), .normal_waiting(normal_waiting),
        .preferential_waiting(preferential_waiting),
        .total_served(total_served), .normal_served(normal_served),
        .preferential_served(preferential_served)
    );
endmodule
`default_nettype wire

>>> design/tcqa_checker.sv
// port-level checks for the ticket queue arbiter and their bind
`default_nettype none
`include "two_class_ticket_queue_arbiter_defines.svh"
module tcqa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  req_type,
    input logic        done,
    input logic [1:0]  status,
    input logic [15:0] ticket_out,
    input logic        ticket_class,
    input logic [16:0] ticket_time,
    input logic [7:0]  queue_position
);
    import tcqa_pkg::*;

    `TCQA_ASSERT_NOW(a_full_zero, clk, rst_n, done && status == ST_FULL, ticket_out == 16'd0 && ticket_time == 17'd0 && queue_position == 8'd0)
    `TCQA_ASSERT_NOW(a_miss_zero, clk, rst_n, done && status == ST_MISSING, ticket_class == 1'b0 && queue_position == 8'd0)
    `TCQA_ASSERT_NOW(a_found_nonzero, clk, rst_n, done && queue_position != 8'd0, ticket_out != 16'd0 && status == ST_OK)
    `TCQA_ASSERT_NEXT(a_issue_one_cycle, clk, rst_n, start && !busy && (req_type == REQ_ISSUE_N || req_type == REQ_ISSUE_P), done && !busy)
endmodule

bind two_class_ticket_queue_arbiter tcqa_checker u_tcqa_checker (.*);
`default_nettype wire
